[hw/rtl/ttcw_pkg.sv]
package ttcw_pkg;

    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 64;
    localparam int HIST_LINES  = 1024;
    localparam int TAB_SPACING = 8;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int HIST_W     = $clog2(HIST_LINES);
    localparam int CELL_AW    = ROW_W + COL_W;
    localparam int HIST_AW    = HIST_W + COL_W;
    localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int HIST_DEPTH = HIST_LINES * MAX_COLS;
    localparam int CNT_W      = CELL_AW + 1;

    localparam int CODE_W = 21;
    localparam int ATTR_W = 16;
    localparam int CELL_W = CODE_W + ATTR_W;

    localparam logic [CODE_W-1:0] SPACE_CODE = 21'd32;
    localparam logic [CODE_W-1:0] CH_LF      = 21'd10;
    localparam logic [CODE_W-1:0] CH_CR      = 21'd13;
    localparam logic [CODE_W-1:0] CH_TAB     = 21'd9;
    localparam logic [CODE_W-1:0] CH_BS      = 21'd8;
    localparam logic [CELL_W-1:0] SPACE_CELL = {16'h0000, SPACE_CODE};

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_GLYPH      = 3'd0;
    localparam cmd_t CMD_SET_CURSOR = 3'd1;
    localparam cmd_t CMD_SET_TAB    = 3'd2;
    localparam cmd_t CMD_CLEAR_TAB  = 3'd3;
    localparam cmd_t CMD_CLEAR_TABS = 3'd4;
    localparam cmd_t CMD_READ_CELL  = 3'd5;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_COLS       = 3'd0;
    localparam cfg_idx_t CFG_ROWS       = 3'd1;
    localparam cfg_idx_t CFG_REGION_EN  = 3'd2;
    localparam cfg_idx_t CFG_REGION_TOP = 3'd3;
    localparam cfg_idx_t CFG_REGION_BOT = 3'd4;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_CELL = 2'd1,
        RD_HIST = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic init_step;
        logic tab_step;
        logic push_step;
        logic shift_step;
        logic clear_step;
        logic tclr_step;
        logic rd_cap;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic go_tab;
        logic go_scroll;
        logic go_tclr;
        logic go_read;
        logic scroll_push;
        logic scroll_shift;
        logic tab_done;
        logic cnt_cols;
        logic cnt_last_col;
        logic shift_end;
    } dp_status_t;

    function automatic logic [MAX_COLS-1:0] tab_init_f();
        logic [MAX_COLS-1:0] v;
        v = '0;
        for (int c = TAB_SPACING; c < MAX_COLS; c += TAB_SPACING) begin
            v[c] = 1'b1;
        end
        return v;
    endfunction

    localparam logic [MAX_COLS-1:0] TAB_INIT = tab_init_f();

    function automatic logic [7:0] clamp_cols(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (v == 8'd0) begin
            r = 8'd1;
        end else if (v > 8'(MAX_COLS)) begin
            r = 8'(MAX_COLS);
        end
        return r;
    endfunction

    function automatic logic [6:0] clamp_rows(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > 7'(MAX_ROWS)) begin
            r = 7'(MAX_ROWS);
        end
        return r;
    endfunction

endpackage

[hw/rtl/ttcw_ram.sv]
module ttcw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ttcw_ctrl.sv]
module ttcw_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  ttcw_pkg::dp_status_t   sts,
    output ttcw_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_EXEC  = 10'b00_0000_0100,
        S_TAB   = 10'b00_0000_1000,
        S_PUSH  = 10'b00_0001_0000,
        S_SHIFT = 10'b00_0010_0000,
        S_CLEAR = 10'b00_0100_0000,
        S_TCLR  = 10'b00_1000_0000,
        S_RD    = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.go_tab) begin
                    state_next = S_TAB;
                end else if (sts.go_scroll) begin
                    if (sts.scroll_push)       state_next = S_PUSH;
                    else if (sts.scroll_shift) state_next = S_SHIFT;
                    else                       state_next = S_CLEAR;
                end else if (sts.go_tclr) begin
                    state_next = S_TCLR;
                end else if (sts.go_read) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_TAB: begin
                cmd.tab_step = 1'b1;
                if (sts.tab_done) state_next = S_DONE;
            end
            S_PUSH: begin
                cmd.push_step = 1'b1;
                if (sts.cnt_cols) state_next = sts.scroll_shift ? S_SHIFT : S_CLEAR;
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (sts.shift_end) state_next = S_CLEAR;
            end
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.cnt_last_col) state_next = S_DONE;
            end
            S_TCLR: begin
                cmd.tclr_step = 1'b1;
                if (sts.cnt_last_col) state_next = S_DONE;
            end
            S_RD: begin
                cmd.rd_cap = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not enter execute");

    a_shift_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && !sts.shift_end) |=> (state_reg == S_SHIFT))
        else $error("row shift left early");

    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_tready) |=>
        (state_reg == S_DONE && m_valid_reg))
        else $error("result overwrote a pending transaction");
`endif

endmodule

[hw/rtl/ttcw_dp.sv]
module ttcw_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ttcw_pkg::ctrl_cmd_t  cmd,
    output ttcw_pkg::dp_status_t sts,
    input  logic [63:0]          s_tdata,
    input  logic [2:0]           s_tuser,
    input  logic                 cfg_wr,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output logic [63:0]          m_tdata
);

    localparam int COL_W   = ttcw_pkg::COL_W;
    localparam int ROW_W   = ttcw_pkg::ROW_W;
    localparam int HIST_W  = ttcw_pkg::HIST_W;
    localparam int CNT_W   = ttcw_pkg::CNT_W;
    localparam int CELL_AW = ttcw_pkg::CELL_AW;
    localparam int HIST_AW = ttcw_pkg::HIST_AW;
    localparam int CELL_W  = ttcw_pkg::CELL_W;
    localparam logic [HIST_W+1:0] HL = (HIST_W + 2)'(ttcw_pkg::HIST_LINES);

    // configuration
    logic [7:0]       act_cols_reg, act_cols_next;
    logic [6:0]       act_rows_reg, act_rows_next;
    logic             reg_en_reg, reg_en_next;
    logic [5:0]       reg_top_reg, reg_top_next;
    logic [5:0]       reg_bot_reg, reg_bot_next;
    // screen state
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [ttcw_pkg::MAX_ROWS-1:0] wrap_reg, wrap_next;
    logic [10:0]      used_reg, used_next;
    logic [HIST_W-1:0] head_reg, head_next;
    logic [HIST_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pv_reg, pv_next;
    // latched item
    ttcw_pkg::cmd_t   cmd_reg;
    logic [20:0]      code_reg;
    logic [15:0]      attr_reg;
    logic [7:0]       col_reg;
    logic [6:0]       row_reg;
    logic [10:0]      view_reg;
    // read result
    ttcw_pkg::rd_src_t rd_src_reg, rd_src_next;
    logic [20:0]      rd_code_reg, rd_code_next;
    logic [15:0]      rd_attr_reg, rd_attr_next;
    logic [63:0]      out_reg;

    // memory ports
    logic               cell_we, cell_re, hist_we, hist_re, tab_we, tab_re, tab_wdata;
    logic [CELL_AW-1:0] cell_waddr, cell_raddr;
    logic [CELL_W-1:0]  cell_wdata, cell_rdata, hist_rdata;
    logic [HIST_AW-1:0] hist_waddr, hist_raddr;
    logic [COL_W-1:0]   tab_waddr, tab_raddr;
    logic               tab_rdata;

    // derived
    logic [7:0]       cols;
    logic [6:0]       rows;
    logic             expl;
    logic [ROW_W-1:0] bottom, lo;
    logic [6:0]       nl;
    logic [7:0]       col_inc;
    logic             printable, nr_needed, nr_soft, scroll_hit;
    logic [CNT_W-1:0] shift_start, shift_end;
    logic [10:0]      off;
    logic [11:0]      line, rsum, psum;
    logic             hist_hit;
    logic [6:0]       sr;
    logic [7:0]       ncols;
    logic [6:0]       nrows;

    ttcw_ram #(.WIDTH(CELL_W), .DEPTH(ttcw_pkg::CELL_DEPTH)) u_cell_ram (
        .aclk(aclk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .re(cell_re), .raddr(cell_raddr), .rdata(cell_rdata)
    );

    ttcw_ram #(.WIDTH(CELL_W), .DEPTH(ttcw_pkg::HIST_DEPTH)) u_hist_ram (
        .aclk(aclk), .we(hist_we), .waddr(hist_waddr), .wdata(cell_rdata),
        .re(hist_re), .raddr(hist_raddr), .rdata(hist_rdata)
    );

    ttcw_ram #(.WIDTH(1), .DEPTH(ttcw_pkg::MAX_COLS)) u_tab_ram (
        .aclk(aclk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .re(tab_re), .raddr(tab_raddr), .rdata(tab_rdata)
    );

    always_comb begin
        cols      = ttcw_pkg::clamp_cols(act_cols_reg);
        rows      = ttcw_pkg::clamp_rows(act_rows_reg);
        expl      = reg_en_reg && (reg_top_reg <= reg_bot_reg) && ({1'b0, reg_bot_reg} < rows);
        bottom    = expl ? reg_bot_reg : ROW_W'(rows - 7'd1);
        lo        = expl ? reg_top_reg : '0;
        nl        = {1'b0, cur_row_reg} + 7'd1;
        col_inc   = {1'b0, cur_col_reg} + 8'd1;
        printable = (code_reg != ttcw_pkg::CH_LF) && (code_reg != ttcw_pkg::CH_CR) &&
                    (code_reg != ttcw_pkg::CH_TAB) && (code_reg != ttcw_pkg::CH_BS);
        nr_needed = (cmd_reg == ttcw_pkg::CMD_GLYPH) &&
                    ((code_reg == ttcw_pkg::CH_LF) || (printable && col_inc >= cols));
        nr_soft   = printable;
        scroll_hit = nr_needed && (nl > {1'b0, bottom});
        shift_start = CNT_W'({1'b0, lo} + 7'd1) << COL_W;
        shift_end   = CNT_W'({1'b0, bottom} + 7'd1) << COL_W;
        // read window
        off      = (view_reg < used_reg) ? view_reg : used_reg;
        line     = 12'(used_reg) - 12'(off) + 12'(row_reg);
        hist_hit = (off != 11'd0) && (line < 12'(used_reg));
        rsum     = 12'(head_reg) + line;
        if (rsum >= 12'(HL)) rsum = rsum - 12'(HL);
        sr       = row_reg - off[6:0];
        psum     = 12'(head_reg) + 12'(used_reg);
        if (psum >= 12'(HL)) psum = psum - 12'(HL);
        ncols    = ttcw_pkg::clamp_cols(cfg_data);
        nrows    = ttcw_pkg::clamp_rows(cfg_data[6:0]);
    end

    always_comb begin
        sts              = '0;
        sts.init_last    = (cnt_reg == CNT_W'(ttcw_pkg::CELL_DEPTH - 1));
        sts.go_tab       = (cmd_reg == ttcw_pkg::CMD_GLYPH) && (code_reg == ttcw_pkg::CH_TAB);
        sts.go_scroll    = scroll_hit;
        sts.go_tclr      = (cmd_reg == ttcw_pkg::CMD_CLEAR_TABS);
        sts.go_read      = (cmd_reg == ttcw_pkg::CMD_READ_CELL);
        sts.scroll_push  = !expl;
        sts.scroll_shift = (bottom > lo);
        sts.tab_done     = (cnt_reg >= CNT_W'(cols)) || tab_rdata;
        sts.cnt_cols     = (cnt_reg == CNT_W'(ttcw_pkg::MAX_COLS));
        sts.cnt_last_col = (cnt_reg == CNT_W'(ttcw_pkg::MAX_COLS - 1));
        sts.shift_end    = (cnt_reg == shift_end);
    end

    always_comb begin
        act_cols_next = act_cols_reg;
        act_rows_next = act_rows_reg;
        reg_en_next   = reg_en_reg;
        reg_top_next  = reg_top_reg;
        reg_bot_next  = reg_bot_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        wrap_next     = wrap_reg;
        used_next     = used_reg;
        head_next     = head_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        pv_next       = pv_reg;
        rd_src_next   = rd_src_reg;
        rd_code_next  = rd_code_reg;
        rd_attr_next  = rd_attr_reg;
        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = ttcw_pkg::SPACE_CELL;
        cell_re    = 1'b0;
        cell_raddr = '0;
        hist_we    = 1'b0;
        hist_waddr = {slot_reg, COL_W'(cnt_reg - 1'b1)};
        hist_re    = 1'b0;
        hist_raddr = '0;
        tab_we     = 1'b0;
        tab_waddr  = cnt_reg[COL_W-1:0];
        tab_wdata  = 1'b0;
        tab_re     = 1'b0;
        tab_raddr  = '0;

        if (cmd.init_step) begin
            // clearing sweep over the whole cell store, tab stops alongside
            cell_we    = 1'b1;
            cell_waddr = cnt_reg[CELL_AW-1:0];
            tab_we     = (cnt_reg < CNT_W'(ttcw_pkg::MAX_COLS));
            tab_wdata  = ttcw_pkg::TAB_INIT[cnt_reg[COL_W-1:0]];
            cnt_next   = sts.init_last ? '0 : cnt_reg + 1'b1;
        end

        if (cmd.exec) begin
            rd_src_next  = ttcw_pkg::RD_NONE;
            rd_code_next = ttcw_pkg::SPACE_CODE;
            rd_attr_next = '0;
            cnt_next     = '0;
            pv_next      = 1'b0;
            case (cmd_reg)
                ttcw_pkg::CMD_GLYPH: begin
                    if (code_reg == ttcw_pkg::CH_CR) begin
                        cur_col_next = '0;
                    end else if (code_reg == ttcw_pkg::CH_TAB) begin
                        cnt_next  = CNT_W'(cur_col_reg) + 1'b1;
                        tab_re    = 1'b1;
                        tab_raddr = cur_col_reg + 1'b1;
                    end else if (code_reg == ttcw_pkg::CH_BS) begin
                        if (cur_col_reg != '0) cur_col_next = cur_col_reg - 1'b1;
                    end else if (printable) begin
                        cell_we    = ({1'b0, cur_row_reg} < rows) && ({1'b0, cur_col_reg} < cols);
                        cell_waddr = {cur_row_reg, cur_col_reg};
                        cell_wdata = {attr_reg, code_reg};
                        cur_col_next = col_inc[COL_W-1:0];
                    end
                    if (nr_needed) begin
                        cur_col_next = '0;
                        if (scroll_hit) begin
                            cur_row_next = bottom;
                            if (!expl) begin
                                cnt_next = '0;
                            end else begin
                                cnt_next = (bottom > lo) ? shift_start : '0;
                            end
                        end else begin
                            cur_row_next = nl[ROW_W-1:0];
                        end
                        if (scroll_hit && !expl) begin
                            // full-screen scroll: marks move up with the rows
                            for (int r = 0; r < ttcw_pkg::MAX_ROWS; r++) begin
                                if (7'(r) < rows - 7'd1) begin
                                    wrap_next[r] = wrap_reg[(r + 1) % ttcw_pkg::MAX_ROWS];
                                end else if (7'(r) == rows - 7'd1) begin
                                    wrap_next[r] = 1'b0;
                                end
                            end
                            if (used_reg < 11'(HL)) begin
                                slot_next = psum[HIST_W-1:0];
                                used_next = used_reg + 11'd1;
                            end else begin
                                slot_next = head_reg;
                                head_next = (12'(head_reg) == 12'(HL) - 12'd1) ? '0
                                          : head_reg + 1'b1;
                            end
                        end else if (nl < rows) begin
                            wrap_next[nl[ROW_W-1:0]] = nr_soft;
                        end
                    end
                end
                ttcw_pkg::CMD_SET_CURSOR: begin
                    cur_col_next = (col_reg < cols) ? col_reg[COL_W-1:0] : COL_W'(cols - 8'd1);
                    cur_row_next = (row_reg < rows) ? row_reg[ROW_W-1:0] : ROW_W'(rows - 7'd1);
                end
                ttcw_pkg::CMD_SET_TAB: begin
                    tab_we    = (col_reg < cols);
                    tab_waddr = col_reg[COL_W-1:0];
                    tab_wdata = 1'b1;
                end
                ttcw_pkg::CMD_CLEAR_TAB: begin
                    tab_we    = (col_reg < 8'(ttcw_pkg::MAX_COLS));
                    tab_waddr = col_reg[COL_W-1:0];
                    tab_wdata = 1'b0;
                end
                ttcw_pkg::CMD_READ_CELL: begin
                    if ((col_reg < cols) && (row_reg < rows)) begin
                        if (hist_hit) begin
                            rd_src_next = ttcw_pkg::RD_HIST;
                            hist_re     = 1'b1;
                            hist_raddr  = {rsum[HIST_W-1:0], col_reg[COL_W-1:0]};
                        end else begin
                            rd_src_next = ttcw_pkg::RD_CELL;
                            cell_re     = 1'b1;
                            cell_raddr  = {sr[ROW_W-1:0], col_reg[COL_W-1:0]};
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.tab_step) begin
            if (cnt_reg >= CNT_W'(cols)) begin
                cur_col_next = COL_W'(cols - 8'd1);
            end else if (tab_rdata) begin
                cur_col_next = cnt_reg[COL_W-1:0];
            end else begin
                cnt_next  = cnt_reg + 1'b1;
                tab_re    = 1'b1;
                tab_raddr = cnt_reg[COL_W-1:0] + 1'b1;
            end
        end

        if (cmd.push_step) begin
            // top row goes to the scrollback ring, one column a cycle
            cell_re    = !sts.cnt_cols;
            cell_raddr = {ROW_W'(0), cnt_reg[COL_W-1:0]};
            hist_we    = pv_reg;
            pv_next    = 1'b1;
            cnt_next   = cnt_reg + 1'b1;
            if (sts.cnt_cols) begin
                pv_next  = 1'b0;
                cnt_next = (bottom > lo) ? shift_start : '0;
            end
        end

        if (cmd.shift_step) begin
            // each cell of the rows below the region top, down to the bottom row, moves up by one row
            cell_re    = !sts.shift_end;
            cell_raddr = cnt_reg[CELL_AW-1:0];
            cell_we    = pv_reg;
            cell_waddr = CELL_AW'(cnt_reg - 1'b1 - CNT_W'(ttcw_pkg::MAX_COLS));
            cell_wdata = cell_rdata;
            pv_next    = 1'b1;
            cnt_next   = cnt_reg + 1'b1;
            if (sts.shift_end) begin
                pv_next  = 1'b0;
                cnt_next = '0;
            end
        end

        if (cmd.clear_step) begin
            cell_we    = 1'b1;
            cell_waddr = {bottom, cnt_reg[COL_W-1:0]};
            cnt_next   = sts.cnt_last_col ? '0 : cnt_reg + 1'b1;
        end

        if (cmd.tclr_step) begin
            tab_we   = 1'b1;
            cnt_next = sts.cnt_last_col ? '0 : cnt_reg + 1'b1;
        end

        if (cmd.rd_cap) begin
            case (rd_src_reg)
                ttcw_pkg::RD_CELL: begin
                    rd_code_next = cell_rdata[20:0];
                    rd_attr_next = cell_rdata[36:21];
                end
                ttcw_pkg::RD_HIST: begin
                    rd_code_next = hist_rdata[20:0];
                    rd_attr_next = hist_rdata[36:21];
                end
                default: begin
                end
            endcase
        end

        if (cfg_wr) begin
            case (cfg_index)
                ttcw_pkg::CFG_COLS: begin
                    act_cols_next = cfg_data;
                    if ({1'b0, cur_col_reg} > ncols - 8'd1) cur_col_next = COL_W'(ncols - 8'd1);
                end
                ttcw_pkg::CFG_ROWS: begin
                    act_rows_next = cfg_data[6:0];
                    if ({1'b0, cur_row_reg} > nrows - 7'd1) cur_row_next = ROW_W'(nrows - 7'd1);
                end
                ttcw_pkg::CFG_REGION_EN:  reg_en_next  = cfg_data[0];
                ttcw_pkg::CFG_REGION_TOP: reg_top_next = cfg_data[5:0];
                ttcw_pkg::CFG_REGION_BOT: reg_bot_next = cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_cols_reg <= 8'd80;
            act_rows_reg <= 7'd24;
            reg_en_reg   <= 1'b0;
            reg_top_reg  <= 6'd0;
            reg_bot_reg  <= 6'd23;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            wrap_reg     <= '0;
            used_reg     <= '0;
            head_reg     <= '0;
            cnt_reg      <= '0;
            pv_reg       <= 1'b0;
            rd_src_reg   <= ttcw_pkg::RD_NONE;
        end else begin
            act_cols_reg <= act_cols_next;
            act_rows_reg <= act_rows_next;
            reg_en_reg   <= reg_en_next;
            reg_top_reg  <= reg_top_next;
            reg_bot_reg  <= reg_bot_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            wrap_reg     <= wrap_next;
            used_reg     <= used_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            pv_reg       <= pv_next;
            rd_src_reg   <= rd_src_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg    <= slot_next;
        rd_code_reg <= rd_code_next;
        rd_attr_reg <= rd_attr_next;
        if (cmd.load) begin
            cmd_reg  <= s_tuser;
            code_reg <= s_tdata[20:0];
            attr_reg <= s_tdata[36:21];
            col_reg  <= s_tdata[44:37];
            row_reg  <= s_tdata[51:45];
            view_reg <= s_tdata[62:52];
        end
        if (cmd.emit) begin
            out_reg <= {3'b000, used_reg, rd_attr_reg, rd_code_reg, cur_row_reg, cur_col_reg};
        end
    end

    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_cursor_in_area: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cur_col_reg} < cols) && ({1'b0, cur_row_reg} < rows))
        else $error("cursor outside the area in use");
`endif

endmodule

[hw/rtl/text_terminal_cell_writer.sv]
// a read passes a capture state after execute before its result is given
// one transaction is worked at a time; a tab walks the tab-stop memory one
// column a cycle until it finds a stop or reaches the right edge
// a scroll pushes the top row to the scrollback ring (full screen only),
// then copies the scrolled rows up and blanks the new bottom row
// clear-all-tabs clears every tab stop in a sweep
// reset: synchronous, active low; then a sweep blanks all 8192 cells
module text_terminal_cell_writer (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // code_point, attribute, column, row, view_offset
    input  logic [2:0]  s_tuser,   // command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // cursor_col, cursor_row, cell_code, cell_attr, history_count
    // register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    ttcw_pkg::ctrl_cmd_t  cmd;
    ttcw_pkg::dp_status_t sts;

    // registers are always writable, the sweep after reset included
    assign cfg_ready = 1'b1;

    // sequencer: walks each command through its passes
    ttcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // cell store, scrollback ring, tab stops, cursor and result register
    ttcw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule
